/* hdl/lpcd_pkg.sv */
package lpcd_pkg;

    // default directory depth and capacity register reset value
    localparam int MAX_ENTRIES_DEF = 16;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_USE   = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // lookup key of one shadow patch
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic        focused;
        logic [63:0] theme;
    } key_t;

    // per-cell update broadcast by the controller
    typedef enum logic [1:0] {
        UPD_NONE  = 2'd0,
        UPD_CLEAR = 2'd1,
        UPD_TOUCH = 2'd2,
        UPD_FILL  = 2'd3
    } upd_op_t;

endpackage

/* hdl/lru_patch_cache_directory.sv */
// LRU patch cache directory: fully associative directory of shadow patch keys.
// Command transactions enter on the s_ stream (command in s_tuser, key and
// dest_empty in s_tdata); one result transaction per command leaves on the
// m_ stream. Capacity is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Entries live in a chain of MAX_ENTRIES cells. A search token walks the
// chain one cell per cycle, gathering hit, oldest entry, lowest free slot and
// eviction count; the controller then broadcasts one update to every cell.
// One command is in flight at a time: a new command is taken only once the
// current one has been resolved and its result handed to the output register.
// s_tready is high only while no command is in flight; the result register
// decouples the output, so a new command is taken while a result waits.
// If m_tready is low when a result is ready, the block holds in its resolve
// step (state untouched) until the output register frees up.
// Reset clears all entries, recency ranks and occupancy, and sets capacity to
// 16; no clearing pass is needed.
module lru_patch_cache_directory #(
    parameter int MAX_ENTRIES = lpcd_pkg::MAX_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] patch_width, [31:16] patch_height, [32] focused,
    // [96:33] theme_key, [97] dest_empty, [103:98] zero
    input  logic [103:0] s_tdata,
    // [1:0] command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] accepted, [1] hit, [5:2] slot, [6] evicted, [10:7] evicted_slot,
    // [15:11] occupancy
    output logic [15:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int RW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic          active;
        logic          hit_found;
        logic [IW-1:0] hit_slot;
        logic [RW-1:0] hit_rank;
        logic [IW-1:0] old_slot;
        logic [RW-1:0] old_rank;
        logic          free_found;
        logic [IW-1:0] free_slot;
        logic [CW-1:0] drop_cnt;
    } carry_t;

    typedef struct packed {
        lpcd_pkg::upd_op_t op;
        logic [IW-1:0]     slot;
        logic [RW-1:0]     rank;
        logic              evict;
    } upd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESOLVE
    } state_t;

    state_t         state_reg;
    lpcd_pkg::cmd_t cmd_reg;
    lpcd_pkg::key_t key_reg;
    logic           dest_empty_reg;
    logic           start_reg;
    carry_t         res_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [4:0]     cap_reg;
    logic           m_tvalid_reg;
    logic           acc_reg, acc_next;
    logic           hit_reg, hit_next;
    logic [3:0]     slot_reg, slot_next;
    logic           ev_reg, ev_next;
    logic [3:0]     evslot_reg, evslot_next;
    logic [4:0]     occ_reg, occ_next;

    logic                   accept;
    logic                   out_free;
    logic                   resolve_go;
    logic                   served;
    logic                   full;
    logic                   cap_big;
    logic [CW-1:0]          eff_cap;
    logic [RW-1:0]          thr;
    upd_t                   upd;
    carry_t                 chain_head;
    carry_t                 chain [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] valid_vec;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign resolve_go = (state_reg == ST_RESOLVE) && out_free;

    // zero or oversize capacity means the full depth
    assign cap_big = (cap_reg == 5'd0) || (32'(cap_reg) > MAX_ENTRIES);
    assign eff_cap = cap_big ? CW'(MAX_ENTRIES) : CW'(cap_reg);
    // entries at this rank or older go on an evicting miss
    assign thr     = RW'(eff_cap - CW'(1));

    assign served = (cmd_reg == lpcd_pkg::CMD_USE) && (key_reg.width != 16'd0) &&
                    (key_reg.height != 16'd0) && !dest_empty_reg;
    assign full   = (count_reg >= eff_cap);

    // search token enters at cell 0
    always_comb
    begin
        chain_head        = '0;
        chain_head.active = start_reg;
    end

    assign chain[0] = chain_head;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lpcd_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .IDX         (i),
            .carry_t     (carry_t),
            .upd_t       (upd_t)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .thr       (thr),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1]),
            .upd       (upd),
            .valid     (valid_vec[i])
        );
    end

    // decision from the finished search
    always_comb
    begin
        upd         = '0;
        count_next  = count_reg;
        acc_next    = 1'b0;
        hit_next    = 1'b0;
        slot_next   = 4'd0;
        ev_next     = 1'b0;
        evslot_next = 4'd0;
        if (resolve_go)
        begin
            case (cmd_reg)
                lpcd_pkg::CMD_CLEAR:
                begin
                    upd.op     = lpcd_pkg::UPD_CLEAR;
                    count_next = '0;
                end
                lpcd_pkg::CMD_PROBE:
                begin
                    hit_next = res_reg.hit_found;
                end
                lpcd_pkg::CMD_USE:
                begin
                    if (served)
                    begin
                        acc_next = 1'b1;
                        if (res_reg.hit_found)
                        begin
                            hit_next = 1'b1;
                            upd.op   = lpcd_pkg::UPD_TOUCH;
                            upd.slot = res_reg.hit_slot;
                            upd.rank = res_reg.hit_rank;
                        end
                        else if (full)
                        begin
                            // reuse the oldest slot, drop everything past capacity
                            upd.op      = lpcd_pkg::UPD_FILL;
                            upd.evict   = 1'b1;
                            upd.slot    = res_reg.old_slot;
                            ev_next     = 1'b1;
                            evslot_next = 4'(res_reg.old_slot);
                            count_next  = count_reg - res_reg.drop_cnt + CW'(1);
                        end
                        else
                        begin
                            upd.op     = lpcd_pkg::UPD_FILL;
                            upd.slot   = res_reg.free_slot;
                            count_next = count_reg + CW'(1);
                        end
                        slot_next = 4'(upd.slot);
                    end
                end
                default:
                begin
                end
            endcase
        end
        occ_next = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            res_reg      <= '0;
            count_reg    <= '0;
            cap_reg      <= lpcd_pkg::CAP_RESET;
            m_tvalid_reg <= 1'b0;
            acc_reg      <= 1'b0;
            hit_reg      <= 1'b0;
            slot_reg     <= 4'd0;
            ev_reg       <= 1'b0;
            evslot_reg   <= 4'd0;
            occ_reg      <= 5'd0;
        end
        else
        begin
            start_reg <= accept;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            // a result handed over while the next one is loaded stays valid
            if (m_tvalid_reg && m_tready && !resolve_go)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (chain[MAX_ENTRIES].active)
                    begin
                        res_reg   <= chain[MAX_ENTRIES];
                        state_reg <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        acc_reg      <= acc_next;
                        hit_reg      <= hit_next;
                        slot_reg     <= slot_next;
                        ev_reg       <= ev_next;
                        evslot_reg   <= evslot_next;
                        occ_reg      <= occ_next;
                        count_reg    <= count_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= lpcd_pkg::cmd_t'(s_tuser);
            key_reg.width  <= s_tdata[15:0];
            key_reg.height <= s_tdata[31:16];
            key_reg.focused <= s_tdata[32];
            key_reg.theme  <= s_tdata[96:33];
            dest_empty_reg <= s_tdata[97];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {occ_reg, evslot_reg, ev_reg, slot_reg, hit_reg, acc_reg};

`ifndef SYNTH
    // occupancy counter tracks the cells' valid bits between commands
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_vec) == 32'(count_reg)))
        else $error("occupancy counter disagrees with cell valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_ENTRIES)
        else $error("occupancy above directory depth");

    // the search token only reaches the tail while a search is running
    a_tail_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain[MAX_ENTRIES].active |-> (state_reg == ST_SEARCH))
        else $error("search token at chain tail outside search");

    // an eviction only comes with a served miss
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[6]) |-> (m_tdata[0] && !m_tdata[1]))
        else $error("eviction reported without a served miss");
`endif

endmodule

/* hdl/lpcd_cell.sv */
module lpcd_cell #(
    parameter int MAX_ENTRIES = lpcd_pkg::MAX_ENTRIES_DEF,
    parameter int IDX = 0,
    parameter type carry_t = struct packed {
        logic                               active;
        logic                               hit_found;
        logic [$clog2(MAX_ENTRIES)-1:0]     hit_slot;
        logic [$clog2(MAX_ENTRIES)-1:0]     hit_rank;
        logic [$clog2(MAX_ENTRIES)-1:0]     old_slot;
        logic [$clog2(MAX_ENTRIES)-1:0]     old_rank;
        logic                               free_found;
        logic [$clog2(MAX_ENTRIES)-1:0]     free_slot;
        logic [$clog2(MAX_ENTRIES + 1)-1:0] drop_cnt;
    },
    parameter type upd_t = struct packed {
        lpcd_pkg::upd_op_t              op;
        logic [$clog2(MAX_ENTRIES)-1:0] slot;
        logic [$clog2(MAX_ENTRIES)-1:0] rank;
        logic                           evict;
    }
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lpcd_pkg::key_t                 key,
    input  logic [$clog2(MAX_ENTRIES)-1:0] thr,
    input  carry_t                         carry_in,
    output carry_t                         carry_out,
    input  upd_t                           upd,
    output logic                           valid
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int RW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic           valid_reg, valid_next;
    logic [RW-1:0]  rank_reg, rank_next;
    lpcd_pkg::key_t key_reg;
    carry_t         carry_reg, carry_next;
    logic           match;
    logic           is_target;
    logic           keep;

    assign match     = valid_reg && (key_reg == key);
    assign is_target = (upd.slot == IW'(IDX));
    assign keep      = valid_reg && !(upd.evict && (rank_reg >= thr));

    // search pass: fold this entry into the running result
    always_comb
    begin
        carry_next = carry_in;
        if (match && !carry_in.hit_found)
        begin
            carry_next.hit_found = 1'b1;
            carry_next.hit_slot  = IW'(IDX);
            carry_next.hit_rank  = rank_reg;
        end
        // later cell wins on equal rank
        if (valid_reg && (rank_reg >= carry_in.old_rank))
        begin
            carry_next.old_slot = IW'(IDX);
            carry_next.old_rank = rank_reg;
        end
        if (!valid_reg && !carry_in.free_found)
        begin
            carry_next.free_found = 1'b1;
            carry_next.free_slot  = IW'(IDX);
        end
        if (valid_reg && (rank_reg >= thr))
        begin
            carry_next.drop_cnt = carry_in.drop_cnt + CW'(1);
        end
    end

    // update from the controller
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        case (upd.op)
            lpcd_pkg::UPD_CLEAR:
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            lpcd_pkg::UPD_TOUCH:
            begin
                if (valid_reg && (rank_reg < upd.rank))
                begin
                    rank_next = rank_reg + RW'(1);
                end
                if (is_target)
                begin
                    rank_next = '0;
                end
            end
            lpcd_pkg::UPD_FILL:
            begin
                valid_next = keep;
                if (keep)
                begin
                    rank_next = rank_reg + RW'(1);
                end
                if (is_target)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((upd.op == lpcd_pkg::UPD_FILL) && is_target)
        begin
            key_reg <= key;
        end
    end

    assign carry_out = carry_reg;
    assign valid     = valid_reg;

endmodule
